>>> design/mexp_pkg.sv
package mexp_pkg;

  // Field widths
  localparam int MOD_W  = 32;
  localparam int BASE_W = 63;
  localparam int EXP_W  = 63;

  // Derived widths
  localparam int MU_W   = MOD_W + 2;            // Barrett reciprocal, up to 2^(n+1)
  localparam int LEN_W  = $clog2(MOD_W + 1);    // bit length of the modulus
  localparam int DIV_W  = 2 * MOD_W + 1;        // serial divider dividend
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam int PROD_W = 2 * MU_W;             // shared multiplier product
  localparam int RED_W  = MOD_W + 2;            // Barrett remainder before correction
  localparam int IDX_W  = (EXP_W > 1) ? $clog2(EXP_W) : 1;

  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1000000007);

  // Modulus context handed to the modular multiplier
  typedef struct packed {
    logic [MOD_W-1:0] modulus;
    logic [MU_W-1:0]  mu;
    logic [LEN_W-1:0] len;
    logic             wrap;   // register holds zero: arithmetic wraps at 2^MOD_W
  } mexp_ctx_t;

endpackage

>>> design/mexp_if.sv
interface mexp_in_if;
  logic                       valid;
  logic                       ready;
  logic [mexp_pkg::BASE_W-1:0] base_value;
  logic [mexp_pkg::EXP_W-1:0]  exponent;

  modport source (output valid, output base_value, output exponent, input ready);
  modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

interface mexp_out_if;
  logic                       valid;
  logic                       ready;
  logic [mexp_pkg::MOD_W-1:0] power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

interface mexp_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [mexp_pkg::MOD_W-1:0] modulus;

  modport source (output valid, output modulus, input ready);
  modport sink   (input valid, input modulus, output ready);
endinterface

>>> design/modular_exponentiation_core.sv
// Sequence: a zero exponent goes straight to the result; else base reduction (none with a zero modulus),
//   a scan step per exponent bit down to the leading one, then the modular products (a square
//   per lower bit plus a multiply per lower set bit), and then the result is presented.
// Throughput: one item at a time; in_ch.ready stays low until the result is registered.
// Reset and every modulus write: bit-length scan plus Barrett reciprocal division (skipped for
//   a zero modulus) with in_ch.ready low; the modulus resets to 1000000007.
module modular_exponentiation_core (
  input  logic        clk,
  input  logic        rst_n,
  mexp_in_if.sink     in_ch,
  mexp_out_if.source  out_ch,
  mexp_cfg_if.sink    cfg_ch
);
  import mexp_pkg::*;

  localparam logic [3:0] ST_LEN  = 4'd0;
  localparam logic [3:0] ST_MU   = 4'd1;
  localparam logic [3:0] ST_IDLE = 4'd2;
  localparam logic [3:0] ST_BASE = 4'd3;
  localparam logic [3:0] ST_SCAN = 4'd4;
  localparam logic [3:0] ST_SQR  = 4'd5;
  localparam logic [3:0] ST_SQW  = 4'd6;
  localparam logic [3:0] ST_MUL  = 4'd7;
  localparam logic [3:0] ST_MLW  = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  logic [3:0]       state_r, state_nxt;
  logic [MOD_W-1:0] mod_r, mod_nxt;
  logic [MOD_W-1:0] tmp_r, tmp_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [MU_W-1:0]  mu_r, mu_nxt;
  logic [EXP_W-1:0] exp_r, exp_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [MOD_W-1:0] b_r, b_nxt;
  logic [MOD_W-1:0] acc_r, acc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [MOD_W-1:0] out_data_r, out_data_nxt;

  logic             in_xfer, cfg_xfer, out_xfer;
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dvd, div_quot;
  logic [MOD_W-1:0] div_rem;
  logic             mm_start, mm_done;
  logic [MOD_W-1:0] mm_b, mm_res;
  mexp_ctx_t        ctx;
  logic             last_bit;

  // Handshakes
  assign in_ch.ready  = (state_r == ST_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = ((state_r == ST_LEN) || (state_r == ST_MU) || (state_r == ST_IDLE))
                        && !out_valid_r;
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign cfg_xfer = cfg_ch.valid && cfg_ch.ready;
  assign out_xfer = out_valid_r && out_ch.ready;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.power_result = out_data_r;

  assign ctx.modulus = mod_r;
  assign ctx.mu      = mu_r;
  assign ctx.len     = len_r;
  assign ctx.wrap    = (mod_r == '0);

  assign mm_start = (state_r == ST_SQR) || (state_r == ST_MUL);
  assign mm_b     = (state_r == ST_MUL) ? b_r : acc_r;
  assign last_bit = (idx_r == '0);

  mexp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (mod_r),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  mexp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mm_start),
    .a     (acc_r),
    .b     (mm_b),
    .ctx   (ctx),
    .done  (mm_done),
    .res   (mm_res)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    mod_nxt       = mod_r;
    tmp_nxt       = tmp_r;
    len_nxt       = len_r;
    mu_nxt        = mu_r;
    exp_nxt       = exp_r;
    idx_nxt       = idx_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    div_dvd       = '0;

    if (out_xfer) out_valid_nxt = 1'b0;

    unique case (state_r)
      // bit length of the modulus, one bit a cycle
      ST_LEN: begin
        priority if (tmp_r != '0) begin
          tmp_nxt = tmp_r >> 1;
          len_nxt = len_r + LEN_W'(1);
        end else if (mod_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          div_start = 1'b1;
          div_dvd   = DIV_W'(1) << {len_r, 1'b0};
          state_nxt = ST_MU;
        end
      end
      // reciprocal floor(2^(2n) / m)
      ST_MU: begin
        if (div_done) begin
          mu_nxt    = div_quot[MU_W-1:0];
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          exp_nxt = in_ch.exponent;
          idx_nxt = IDX_W'(EXP_W - 1);
          priority if (in_ch.exponent == '0) begin
            acc_nxt   = MOD_W'(1);
            state_nxt = ST_DONE;
          end else if (ctx.wrap) begin
            b_nxt     = in_ch.base_value[MOD_W-1:0];
            state_nxt = ST_SCAN;
          end else begin
            div_start = 1'b1;
            div_dvd   = DIV_W'(in_ch.base_value);
            state_nxt = ST_BASE;
          end
        end
      end
      ST_BASE: begin
        if (div_done) begin
          b_nxt     = div_rem;
          state_nxt = ST_SCAN;
        end
      end
      // skip leading zero bits; the first set bit loads the reduced base
      ST_SCAN: begin
        if (exp_r[idx_r]) begin
          acc_nxt = b_r;
          if (last_bit) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            state_nxt = ST_SQR;
          end
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
        end
      end
      ST_SQR: state_nxt = ST_SQW;
      ST_SQW: begin
        if (mm_done) begin
          acc_nxt = mm_res;
          priority if (exp_r[idx_r]) begin
            state_nxt = ST_MUL;
          end else if (last_bit) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            state_nxt = ST_SQR;
          end
        end
      end
      ST_MUL: state_nxt = ST_MLW;
      ST_MLW: begin
        if (mm_done) begin
          acc_nxt = mm_res;
          if (last_bit) begin
            state_nxt = ST_DONE;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            state_nxt = ST_SQR;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // modulus write restarts the reciprocal precompute
    if (cfg_xfer) begin
      mod_nxt   = cfg_ch.modulus;
      tmp_nxt   = cfg_ch.modulus;
      len_nxt   = '0;
      state_nxt = ST_LEN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LEN;
      mod_r       <= MOD_RESET;
      tmp_r       <= MOD_RESET;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mod_r       <= mod_nxt;
      tmp_r       <= tmp_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mu_r       <= mu_nxt;
    exp_r      <= exp_nxt;
    idx_r      <= idx_nxt;
    b_r        <= b_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> design/mexp_div.sv
module mexp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mexp_pkg::DIV_W-1:0]  dividend,
  input  logic [mexp_pkg::MOD_W-1:0]  divisor,
  output logic                        done,
  output logic [mexp_pkg::DIV_W-1:0]  quotient,
  output logic [mexp_pkg::MOD_W-1:0]  remainder
);
  import mexp_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]  dvd_r, dvd_nxt;
  logic [MOD_W-1:0]  rem_r, rem_nxt;

  logic [MOD_W:0]    trial;
  logic [MOD_W:0]    diff;
  logic              ge;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  assign trial = {rem_r, dvd_r[DIV_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // quotient bits shift in where the dividend bits leave
      dvd_nxt = {dvd_r[DIV_W-2:0], ge};
      rem_nxt = ge ? diff[MOD_W-1:0] : trial[MOD_W-1:0];
      cnt_nxt = cnt_r + DCNT_W'(1);
      if (cnt_r == DCNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

>>> design/mexp_mulmod.sv
module mexp_mulmod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mexp_pkg::MOD_W-1:0] a,
  input  logic [mexp_pkg::MOD_W-1:0] b,
  input  mexp_pkg::mexp_ctx_t        ctx,
  output logic                       done,
  output logic [mexp_pkg::MOD_W-1:0] res
);
  import mexp_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_Q    = 2'd1;   // product ready, estimate quotient
  localparam logic [1:0] PH_QM   = 2'd2;   // quotient ready, multiply by modulus
  localparam logic [1:0] PH_R    = 2'd3;   // subtract and correct

  logic [1:0]        ph_r, ph_nxt;
  logic              done_r, done_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [RED_W-1:0]  x_r, x_nxt;
  logic [MOD_W-1:0]  res_r, res_nxt;

  logic [MU_W-1:0]     mul_a, mul_b;
  logic [2*MOD_W-1:0]  x_shift;
  logic [MOD_W:0]      q1;
  logic [PROD_W-1:0]   t_shift;
  logic [MOD_W-1:0]    q;
  logic [RED_W-1:0]    m_ext, r0, r1, r2;

  // Barrett quotient estimate: q = ((x >> (n-1)) * mu) >> (n+1)
  assign x_shift = prod_r[2*MOD_W-1:0] >> (ctx.len - LEN_W'(1));
  assign q1      = x_shift[MOD_W:0];
  assign t_shift = prod_r >> (ctx.len + LEN_W'(1));
  assign q       = t_shift[MOD_W-1:0];

  // Remainder is below three moduli; two conditional subtracts finish it
  assign m_ext = {2'b00, ctx.modulus};
  assign r0    = x_r - prod_r[RED_W-1:0];
  assign r1    = (r0 >= m_ext) ? (r0 - m_ext) : r0;
  assign r2    = (r1 >= m_ext) ? (r1 - m_ext) : r1;

  // Operand select for the shared multiplier
  always_comb begin
    unique case (ph_r)
      PH_IDLE: begin
        mul_a = MU_W'(a);
        mul_b = MU_W'(b);
      end
      PH_Q: begin
        mul_a = MU_W'(q1);
        mul_b = ctx.mu;
      end
      PH_QM: begin
        mul_a = MU_W'(q);
        mul_b = MU_W'(ctx.modulus);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Phase sequencer
  always_comb begin
    ph_nxt   = ph_r;
    done_nxt = 1'b0;
    x_nxt    = x_r;
    res_nxt  = res_r;
    unique case (ph_r)
      PH_IDLE: begin
        if (start) ph_nxt = PH_Q;
      end
      PH_Q: begin
        x_nxt = prod_r[RED_W-1:0];
        if (ctx.wrap) begin
          res_nxt  = prod_r[MOD_W-1:0];
          done_nxt = 1'b1;
          ph_nxt   = PH_IDLE;
        end else begin
          ph_nxt = PH_QM;
        end
      end
      PH_QM: begin
        ph_nxt = PH_R;
      end
      default: begin
        res_nxt  = r2[MOD_W-1:0];
        done_nxt = 1'b1;
        ph_nxt   = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    x_r    <= x_nxt;
    res_r  <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

>>> design/mexp_checker.sv
module mexp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mexp_pkg::MOD_W-1:0] power_result,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [mexp_pkg::MOD_W-1:0] cfg_modulus
);
  import mexp_pkg::*;

  logic [MOD_W-1:0] mod_shadow_r;

  // Track the modulus as written through the port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_shadow_r <= MOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mod_shadow_r <= cfg_modulus;
    end
  end

  // A stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(power_result))
    else $error("result dropped or changed while stalled");

  // One item at a time: busy right after an input transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // A modulus write starts the precompute, so no input is taken next
  assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken during reciprocal precompute");

  // Results lie below the modulus when the modulus is neither zero nor one
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (mod_shadow_r != '0) && (mod_shadow_r != MOD_W'(1))
      |-> power_result < mod_shadow_r)
    else $error("result not reduced");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .power_result (out_ch.power_result),
  .cfg_valid    (cfg_ch.valid),
  .cfg_ready    (cfg_ch.ready),
  .cfg_modulus  (cfg_ch.modulus)
);
